[rtl/core/ean13sw_pkg.sv]
package ean13sw_pkg;

  typedef struct packed {
    logic       valid;
    logic       odd;
    logic [3:0] digit;
  } sym_cell_t;

  typedef struct packed {
    logic [3:0] idx;
    logic [3:0] lead_digit;
    logic       fd_ready;
    logic       fd_valid;
  } lead_info_t;

  localparam int unsigned LeftCount = 6;
  localparam logic [3:0]  LastIdx   = 4'd11;
  localparam logic [3:0]  LeadIdx   = 4'd5;
  localparam logic [3:0]  FirstIdx  = 4'd0;

  // {valid, odd, digit}; index = q1i*12 + q2i*3 + q4i
  localparam logic [5:0] SYM_TABLE [0:47] = '{
    6'h26, 6'h26, 6'h26, 6'h30, 6'h30, 6'h30,
    6'h24, 6'h24, 6'h24, 6'h33, 6'h33, 6'h33,
    6'h39, 6'h39, 6'h39, 6'h00, 6'h22, 6'h28,
    6'h37, 6'h31, 6'h00, 6'h25, 6'h25, 6'h25,
    6'h29, 6'h29, 6'h29, 6'h38, 6'h32, 6'h00,
    6'h21, 6'h27, 6'h00, 6'h35, 6'h35, 6'h35,
    6'h36, 6'h36, 6'h36, 6'h20, 6'h20, 6'h20,
    6'h34, 6'h34, 6'h34, 6'h23, 6'h23, 6'h23
  };

  function automatic sym_cell_t sym_lookup(input logic [1:0] q1i, input logic [1:0] q2i,
                                           input logic [1:0] q4i);
    logic [5:0] idx;
    logic [5:0] entry;
    idx   = 6'({q1i, 2'b00}) * 6'd3 + 6'({q2i, 2'b00}) - 6'(q2i) + 6'(q4i);
    entry = SYM_TABLE[idx];
    return '{valid: entry[5], odd: entry[4], digit: entry[3:0]};
  endfunction

  // returns {hit, digit}
  function automatic logic [4:0] lead_decode(input logic [5:0] pat);
    logic [4:0] r;
    unique case (pat)
      6'h3F:   r = {1'b1, 4'd0};
      6'h0B:   r = {1'b1, 4'd1};
      6'h13:   r = {1'b1, 4'd2};
      6'h23:   r = {1'b1, 4'd3};
      6'h0D:   r = {1'b1, 4'd4};
      6'h19:   r = {1'b1, 4'd5};
      6'h31:   r = {1'b1, 4'd6};
      6'h15:   r = {1'b1, 4'd7};
      6'h25:   r = {1'b1, 4'd8};
      6'h29:   r = {1'b1, 4'd9};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/ean13sw_quant.sv]
module ean13sw_quant import ean13sw_pkg::*; #(
  parameter int unsigned W = 12
) (
  input  logic [W:0]   x,
  input  logic [W+1:0] t,
  output logic [2:0]   q
);

  localparam int unsigned PW = W + 6;

  logic [PW-1:0] xe, te, v, t3, t5, t7, t9;

  assign xe = PW'(x);
  assign te = PW'(t);
  assign v  = (xe << 4) - (xe << 1);
  assign t3 = (te << 1) + te;
  assign t5 = (te << 2) + te;
  assign t7 = (te << 3) - te;
  assign t9 = (te << 3) + te;

  always_comb begin
    if (v <= t3) begin
      q = 3'd1;
    end else if (v < t5) begin
      q = 3'd2;
    end else if (v < t7) begin
      q = 3'd3;
    end else if (v < t9) begin
      q = 3'd4;
    end else begin
      q = 3'd5;
    end
  end

endmodule

[rtl/core/ean13sw_track.sv]
module ean13sw_track import ean13sw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic       restart,
  input  sym_cell_t  sym,
  output logic       left_half,
  output lead_info_t info
);

  logic [3:0] count_r, count_nxt;
  logic [5:0] parity_r, parity_nxt;
  logic       ok_r, ok_nxt;
  logic [3:0] idx;
  logic [4:0] lead;

  always_comb begin
    idx = restart ? FirstIdx : count_r;
    if (idx > LastIdx) begin
      idx = FirstIdx;
    end
  end

  assign left_half = (idx < 4'(LeftCount));

  always_comb begin
    parity_nxt = parity_r;
    ok_nxt     = ok_r;
    if (left_half) begin
      if (idx == FirstIdx) begin
        parity_nxt = {5'd0, sym.odd};
        ok_nxt     = sym.valid;
      end else begin
        parity_nxt = parity_r | (6'(sym.odd) << idx[2:0]);
        ok_nxt     = ok_r & sym.valid;
      end
    end
    count_nxt = (idx == LastIdx) ? FirstIdx : idx + 4'd1;
  end

  assign lead = lead_decode(parity_nxt);

  always_comb begin
    info.idx        = idx;
    info.fd_ready   = (idx == LeadIdx);
    info.fd_valid   = info.fd_ready & lead[4] & ok_nxt;
    info.lead_digit = info.fd_valid ? lead[3:0] : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 4'd0;
      parity_r <= 6'd0;
      ok_r     <= 1'b1;
    end else if (fire) begin
      count_r  <= count_nxt;
      parity_r <= parity_nxt;
      ok_r     <= ok_nxt;
    end
  end

endmodule

[rtl/core/ean13_symbol_width_decoder.sv]
// EAN-13 symbol width decoder.
// Path from input transaction to result: input register, then result register.
// Throughput: one symbol per cycle; a new transaction is taken every cycle while
// the result side keeps up.
// Reset (synchronous, rst_n low): pipeline empties, symbol count and parity pattern
// clear, pattern-ok sets.
module ean13_symbol_width_decoder import ean13sw_pkg::*; #(
  parameter int unsigned RUN_WIDTH_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [RUN_WIDTH_BITS-1:0] in_run_a,
  input  logic [RUN_WIDTH_BITS-1:0] in_run_b,
  input  logic [RUN_WIDTH_BITS-1:0] in_run_c,
  input  logic [RUN_WIDTH_BITS-1:0] in_run_d,
  input  logic                      in_restart,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                out_digit,
  output logic                      out_odd_parity,
  output logic                      out_symbol_valid,
  output logic [3:0]                out_symbol_index,
  output logic [3:0]                out_first_digit,
  output logic                      out_first_digit_ready,
  output logic                      out_first_digit_valid
);

  localparam int unsigned W = RUN_WIDTH_BITS;

  logic [W-1:0] a_r, b_r, c_r, d_r;
  logic         restart_r;
  logic         s1_valid_r;
  logic         out_valid_r;
  logic         adv_out, adv_in, fire;

  logic [W+1:0] t;
  logic [W:0]   t1, t2, t4;
  logic [2:0]   q1, q2, q4;
  logic [1:0]   q1i, q2i, q4i;
  logic         left_half;
  sym_cell_t    sym;
  lead_info_t   info;

  sym_cell_t    sym_r;
  lead_info_t   info_r;

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_in   = !s1_valid_r || adv_out;
  assign fire     = s1_valid_r && adv_out;
  assign in_stall = !adv_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv_in) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      a_r       <= in_run_a;
      b_r       <= in_run_b;
      c_r       <= in_run_c;
      d_r       <= in_run_d;
      restart_r <= in_restart;
    end
  end

  // edge-to-similar-edge sums; left symbols are read mirrored
  assign t  = (W+2)'(a_r) + (W+2)'(b_r) + (W+2)'(c_r) + (W+2)'(d_r);
  assign t2 = (W+1)'(b_r) + (W+1)'(c_r);
  assign t1 = left_half ? (W+1)'(c_r) + (W+1)'(d_r) : (W+1)'(a_r) + (W+1)'(b_r);
  assign t4 = left_half ? (W+1)'(a_r) : (W+1)'(d_r);

  ean13sw_quant #(.W(W)) u_q1 (.x(t1), .t(t), .q(q1));
  ean13sw_quant #(.W(W)) u_q2 (.x(t2), .t(t), .q(q2));
  ean13sw_quant #(.W(W)) u_q4 (.x(t4), .t(t), .q(q4));

  assign q1i = (q1 < 3'd2) ? 2'd0 : 2'(q1 - 3'd2);
  assign q2i = (q2 < 3'd2) ? 2'd0 : 2'(q2 - 3'd2);
  assign q4i = (q4 > 3'd3) ? 2'd2 : 2'(q4 - 3'd1);
  assign sym = sym_lookup(q1i, q2i, q4i);

  ean13sw_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .restart   (restart_r),
    .sym       (sym),
    .left_half (left_half),
    .info      (info)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sym_r  <= sym;
      info_r <= info;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_digit             = sym_r.digit;
  assign out_odd_parity        = sym_r.odd;
  assign out_symbol_valid      = sym_r.valid;
  assign out_symbol_index      = info_r.idx;
  assign out_first_digit       = info_r.lead_digit;
  assign out_first_digit_ready = info_r.fd_ready;
  assign out_first_digit_valid = info_r.fd_valid;

endmodule
